/* design/fastload_record_encoder_unit_macros.svh */
// Assertion helpers for the fastload record encoder.
// All properties sample on clk_i and are suspended while rst_ni is low.
`ifndef FASTLOAD_RECORD_ENCODER_UNIT_MACROS_SVH
`define FASTLOAD_RECORD_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FLRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/flre_pkg.sv */
`default_nettype none
package flre_pkg;

  localparam int RECORD_BYTES = 48;
  localparam int RF_W         = 6;

  // configuration register indexes
  localparam logic REG_IMAGE_LENGTH  = 1'b0;
  localparam logic REG_START_ADDRESS = 1'b1;

  // characters
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_FLAG = 8'h80;

  // record sections a job may carry, in output order
  localparam int N_SEC = 5;
  localparam logic [2:0] SEC_ADDR  = 3'd0;
  localparam logic [2:0] SEC_HEAD  = 3'd1;
  localparam logic [2:0] SEC_GROUP = 3'd2;
  localparam logic [2:0] SEC_TAIL  = 3'd3;
  localparam logic [2:0] SEC_CSUM  = 3'd4;

  // queue between front and back
  localparam int QUEUE_AW = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic [N_SEC-1:0] sec;     // which sections to send
    logic [RF_W-1:0]  len;     // record length field
    logic [23:0]      addr;    // start address snapshot
    logic [23:0]      grp;     // packed group bytes
    logic [31:0]      sum;     // image byte sum snapshot
  } job_t;

  function automatic logic [7:0] hex_up(input logic [3:0] n);
    hex_up = (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h37 + 8'(n));
  endfunction

  function automatic logic [7:0] hex_lo(input logic [3:0] n);
    hex_lo = (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h57 + 8'(n));
  endfunction

  // index of the lowest set section bit
  function automatic logic [2:0] first_sec(input logic [N_SEC-1:0] m);
    logic [2:0] r;
    r = SEC_ADDR;
    for (int i = N_SEC - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    first_sec = r;
  endfunction

  // sections strictly after s
  function automatic logic [N_SEC-1:0] secs_after(input logic [2:0] s);
    logic [N_SEC-1:0] m;
    for (int i = 0; i < N_SEC; i++) begin
      m[i] = (3'(i) > s);
    end
    secs_after = m;
  endfunction

endpackage
`default_nettype wire

/* design/fastload_record_encoder_unit.sv */
// Fastload record encoder: binary image bytes in, fastload text characters out.
// Slave stream (s_axis_*) takes one image byte per transfer. Master stream
// (m_axis_*) sends one character per transfer; tlast marks the last character
// caused by an input byte, tuser marks the final newline of the checksum record.
// Configuration (cfg_*): write image length (index 0) and start address
// (index 1) while the block is idle. Bytes past the image length are taken and
// dropped silently.
// Timing: the front takes one byte per cycle while its two-entry job queue has
// room; the back sends one character per cycle from the queue head unless the
// output stalls. A byte's first character goes through a queue entry and the
// output register to m_axis. Throughput is set by the character rate of the
// back: about 70 characters per 48-byte record, with bursts of up to 34
// characters when one byte both opens and closes the image.
// Reset: registers go to image length 1, start address 0; all counters clear,
// queue and output register empty.
// Stall: when m_axis_tready is low the character holds; the queue fills and
// then s_axis_tready drops, with no loss.
`default_nettype none
module fastload_record_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast,   // run_end
  output logic             m_axis_tuser    // [0] image_done
);
  import flre_pkg::*;

  logic push, full, pop, head_valid;
  job_t push_job, head_job;

  // classify bytes, track record and group position
  flre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .job_push_o   (push),
    .job_o        (push_job),
    .queue_full_i (full)
  );

  flre_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // character sequencer with output register
  flre_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* design/flre_front.sv */
`default_nettype none
module flre_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_addr_i,
  input  wire logic [23:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  output logic               job_push_o,
  output flre_pkg::job_t     job_o,
  input  wire logic          queue_full_i
);
  import flre_pkg::*;

  logic [23:0]     img_len_q, start_addr_q;
  logic [23:0]     seen_q, seen_d;
  logic [RF_W-1:0] rfill_q, rfill_d;
  logic [15:0]     gbits_q, gbits_d;
  logic [1:0]      gfill_q, gfill_d;
  logic [31:0]     bsum_q, bsum_d;

  logic            accept, active, is_last, rec_end, do_grp;
  logic [23:0]     remaining, grp_v;
  logic [RF_W-1:0] len;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign active     = seen_q < img_len_q;

  always_comb begin
    remaining = img_len_q - seen_q;
    len       = (remaining < 24'(RECORD_BYTES)) ? remaining[RF_W-1:0] : RF_W'(RECORD_BYTES);
    grp_v     = {8'h00, gbits_q} | (24'(in_byte_i) << {gfill_q, 3'b000});
    seen_d    = seen_q + 24'd1;
    rfill_d   = rfill_q + RF_W'(1);
    gfill_d   = gfill_q + 2'd1;
    bsum_d    = bsum_q + 32'(in_byte_i);
    is_last   = (seen_d == img_len_q);
    rec_end   = is_last || (rfill_d >= RF_W'(RECORD_BYTES));
    do_grp    = (gfill_q == 2'd2) || rec_end;
    gbits_d   = do_grp ? 16'h0000 : grp_v[15:0];

    job_o.sec            = '0;
    job_o.sec[SEC_ADDR]  = (seen_q == 24'd0);
    job_o.sec[SEC_HEAD]  = (rfill_q == '0);
    job_o.sec[SEC_GROUP] = do_grp;
    job_o.sec[SEC_TAIL]  = rec_end;
    job_o.sec[SEC_CSUM]  = is_last;
    job_o.len            = len;
    job_o.addr           = start_addr_q;
    job_o.grp            = grp_v;
    job_o.sum            = bsum_d;
  end

  // a byte in the middle of a group produces nothing and is not queued
  assign job_push_o = accept && active && (job_o.sec != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_len_q    <= 24'd1;
      start_addr_q <= 24'd0;
      seen_q       <= '0;
      rfill_q      <= '0;
      gbits_q      <= '0;
      gfill_q      <= '0;
      bsum_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_IMAGE_LENGTH:  img_len_q    <= cfg_data_i;
          REG_START_ADDRESS: start_addr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && active) begin
        seen_q  <= seen_d;
        rfill_q <= rec_end ? '0 : rfill_d;
        gbits_q <= gbits_d;
        gfill_q <= do_grp ? 2'd0 : gfill_d;
        bsum_q  <= bsum_d;
      end
    end
  end

endmodule
`default_nettype wire

/* design/flre_queue.sv */
`default_nettype none
module flre_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire flre_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output flre_pkg::job_t     head_job_o
);
  import flre_pkg::*;

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign full_o       = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QUEUE_AW'(1);
      if (pop_i)  rd_q <= rd_q + QUEUE_AW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/flre_back.sv */
`default_nettype none
module flre_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire flre_pkg::job_t head_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               out_last_o,
  output logic               out_done_o
);
  import flre_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] sec_q, sec_d;
  logic [3:0] step_q, step_d;
  logic [7:0] hsum_q, hsum_d;
  logic [7:0] rsum_q, rsum_d;
  logic       ovalid_q;
  logic [7:0] ochar_q;
  logic       olast_q, odone_q;

  logic             take, sec_end, job_end;
  logic [2:0]       sec, k;
  logic [3:0]       step, last_step;
  logic [7:0]       ch;
  logic [3:0]       nib;
  logic [N_SEC-1:0] rest;

  assign take = head_valid_i && (!ovalid_q || out_ready_i);

  always_comb begin
    sec  = busy_q ? sec_q  : first_sec(head_job_i.sec);
    step = busy_q ? step_q : 4'd0;
    k    = '0;
    nib  = '0;
    ch   = CH_NL;
    last_step = 4'd0;

    case (sec)
      SEC_ADDR: begin
        last_step = 4'd10;
        k   = 3'(4'd7 - step);
        nib = 4'(head_job_i.addr >> {k, 2'b00});
        case (step)
          4'd0:    ch = CH_LBR;
          4'd1:    ch = CH_A;
          4'd8:    ch = hex_up(hsum_q[7:4]);
          4'd9:    ch = hex_up(hsum_q[3:0]);
          4'd10:   ch = CH_NL;
          default: ch = hex_lo(nib);
        endcase
      end
      SEC_HEAD: begin
        last_step = 4'd2;
        case (step)
          4'd0:    ch = CH_LBR;
          4'd1:    ch = CH_D;
          default: ch = CH_FLAG | 8'(head_job_i.len);
        endcase
      end
      SEC_GROUP: begin
        last_step = 4'd3;
        case (step)
          4'd0:    ch = CH_FLAG | 8'(head_job_i.grp[5:0]);
          4'd1:    ch = CH_FLAG | 8'(head_job_i.grp[11:6]);
          4'd2:    ch = CH_FLAG | 8'(head_job_i.grp[17:12]);
          default: ch = CH_FLAG | 8'(head_job_i.grp[23:18]);
        endcase
      end
      SEC_TAIL: begin
        last_step = 4'd2;
        case (step)
          4'd0:    ch = hex_up(rsum_q[7:4]);
          4'd1:    ch = hex_up(rsum_q[3:0]);
          default: ch = CH_NL;
        endcase
      end
      default: begin
        last_step = 4'd12;
        k   = 3'(4'd9 - step);
        nib = 4'(head_job_i.sum >> {k, 2'b00});
        case (step)
          4'd0:    ch = CH_LBR;
          4'd1:    ch = CH_C;
          4'd10:   ch = hex_up(hsum_q[7:4]);
          4'd11:   ch = hex_up(hsum_q[3:0]);
          4'd12:   ch = CH_NL;
          default: ch = hex_up(nib);
        endcase
      end
    endcase

    sec_end = (step == last_step);
    rest    = head_job_i.sec & secs_after(sec);
    job_end = sec_end && (rest == '0);

    busy_d = busy_q;
    sec_d  = sec_q;
    step_d = step_q;
    hsum_d = hsum_q;
    rsum_d = rsum_q;
    if (take) begin
      if (job_end) begin
        busy_d = 1'b0;
      end else if (sec_end) begin
        busy_d = 1'b1;
        sec_d  = first_sec(rest);
        step_d = 4'd0;
      end else begin
        busy_d = 1'b1;
        sec_d  = sec;
        step_d = step + 4'd1;
      end
      // running sums of the address/checksum record and of the data record
      if ((sec == SEC_ADDR && step < 4'd8) || (sec == SEC_CSUM && step < 4'd10)) begin
        hsum_d = (step == 4'd0) ? ch : hsum_q + ch;
      end
      if (sec == SEC_HEAD) begin
        rsum_d = (step == 4'd0) ? ch : rsum_q + ch;
      end else if (sec == SEC_GROUP) begin
        rsum_d = rsum_q + ch;
      end
    end
  end

  assign pop_o       = take && job_end;
  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;
  assign out_done_o  = odone_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      ochar_q <= ch;
      olast_q <= job_end;
      odone_q <= (sec == SEC_CSUM) && sec_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      sec_q    <= SEC_ADDR;
      step_q   <= '0;
      hsum_q   <= '0;
      rsum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sec_q  <= sec_d;
      step_q <= step_d;
      hsum_q <= hsum_d;
      rsum_q <= rsum_d;
      if (take)             ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* design/flre_checker.sv */
`default_nettype none
`include "fastload_record_encoder_unit_macros.svh"
module flre_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);

  // a stalled character holds
  `FLRE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled character changed")

  // image end closes the run of its byte
  `FLRE_ASSERT_NOW(a_done_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "image end without run end")

  // image end is the checksum record newline
  `FLRE_ASSERT_NOW(a_done_nl, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'h0A, "image end not on newline")

  // a run ends on a record newline or a flag character (bit 7 set)
  `FLRE_ASSERT_NOW(a_last_char, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'h0A || m_axis_tdata[7], "run end on unexpected character")

endmodule

bind fastload_record_encoder_unit flre_checker u_flre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
